>>> sv/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
package mme_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned ACC_W    = 38;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_CALC   = 2'd2
  } op_e;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic data_valid;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
  } mac_stat_t;

endpackage

>>> sv/mme_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mme_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mme_mac.sv
// Multiply-accumulate unit: registered product, then a wrapping 38-bit accumulate.
module mme_mac #(
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mme_pkg::mac_ctrl_t             ctrl_i,
  input  logic signed [ELEMENT_BITS-1:0] a_i,
  input  logic signed [ELEMENT_BITS-1:0] b_i,
  output logic [mme_pkg::ACC_W-1:0]      acc_o,
  output mme_pkg::mac_stat_t             stat_o
);
  import mme_pkg::*;

  logic signed [2*ELEMENT_BITS-1:0] prod_q;
  logic                             prod_vld_q;
  logic [ACC_W-1:0]                 acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.data_valid) begin
      prod_q <= (2*ELEMENT_BITS)'(a_i) * (2*ELEMENT_BITS)'(b_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.data_valid;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        // signed cast sign-extends (or wraps) the product to accumulator width
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign acc_o       = acc_q;
  assign stat_o.busy = prod_vld_q;

endmodule

>>> sv/matrix_multiply_engine.sv
// Matrix multiply engine: C[row][col] = sum over k of A[row][k] * B[k][col].
// Loads are taken one word per cycle while the engine is idle.
// In-range compute word: one MAC step per k through the single read port of each
//   element RAM; next word taken once the result is loaded into the output register.
// Out-of-range word: skips the MAC walk and finishes with a zero result.
// Reset clears control, sets n to 64; element RAMs are not cleared and hold garbage.
module matrix_multiply_engine #(
  parameter int unsigned MAX_DIM      = 64,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [mme_pkg::SIZE_W-1:0]          cfg_wr_data_i,   // matrix_size
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // opcode[1:0], row_index[7:2], col_index[13:8], load_value[29:14], zero pad
  input  logic [mme_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // result_row[5:0], result_col[11:6], product_value[49:12], zero pad
  output logic [mme_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // out_of_range[0]
  output logic [0:0]                          m_axis_tuser_o
);
  import mme_pkg::*;

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW     = $clog2(MAX_DIM + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // input word fields
  logic [OP_W-1:0]  in_op;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [VAL_W-1:0] in_val;
  assign in_op  = s_axis_tdata_i[1:0];
  assign in_row = s_axis_tdata_i[7:2];
  assign in_col = s_axis_tdata_i[13:8];
  assign in_val = s_axis_tdata_i[29:14];

  logic [SIZE_W-1:0] matrix_size_q;
  logic [1:0]        state_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              oor_q;
  logic [NW-1:0]     k_q;
  logic              rd_vld_q;

  logic              out_vld_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ACC_W-1:0]  out_val_q;
  logic              out_oor_q;

  logic [NW-1:0]           n_eff;
  logic                    in_acc;
  logic                    in_store;
  logic                    in_oor;
  logic                    we_a;
  logic                    we_b;
  logic                    is_calc;
  logic                    rd_en;
  logic                    out_free;
  logic [ADDR_W-1:0]       waddr;
  logic [ADDR_W-1:0]       a_raddr;
  logic [ADDR_W-1:0]       b_raddr;
  logic [ELEMENT_BITS-1:0] wdata;
  logic [ELEMENT_BITS-1:0] a_rdata;
  logic [ELEMENT_BITS-1:0] b_rdata;
  logic [ACC_W-1:0]        acc;
  mac_ctrl_t               mac_ctrl;
  mac_stat_t               mac_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= SIZE_RESET;
    end else if (cfg_wr_en_i) begin
      matrix_size_q <= cfg_wr_data_i;
    end
  end

  // sizes above the store act as the full store
  assign n_eff = (32'(matrix_size_q) > MAX_DIM) ? NW'(MAX_DIM) : NW'(matrix_size_q);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_store = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign in_oor   = (32'(in_row) >= 32'(n_eff)) || (32'(in_col) >= 32'(n_eff));
  assign waddr    = ADDR_W'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign wdata    = ELEMENT_BITS'($unsigned(in_val));

  always_comb begin
    we_a    = 1'b0;
    we_b    = 1'b0;
    is_calc = 1'b0;
    case (in_op)
      OP_LOAD_A: we_a    = in_acc && in_store;
      OP_LOAD_B: we_b    = in_acc && in_store;
      OP_CALC:   is_calc = in_acc;
      default: begin
        we_a    = 1'b0;
        we_b    = 1'b0;
        is_calc = 1'b0;
      end
    endcase
  end

  // A walks along the row, B down the column
  assign rd_en   = (state_q == ST_CALC) && (k_q < n_eff);
  assign a_raddr = ADDR_W'(32'(row_q) * MAX_DIM + 32'(k_q));
  assign b_raddr = ADDR_W'(32'(k_q) * MAX_DIM + 32'(col_q));

  mme_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mme_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign mac_ctrl.clear      = is_calc;
  assign mac_ctrl.data_valid = rd_vld_q;

  mme_mac #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    ($signed(a_rdata)),
    .b_i    ($signed(b_rdata)),
    .acc_o  (acc),
    .stat_o (mac_stat)
  );

  assign out_free = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      rd_vld_q  <= 1'b0;
      oor_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (state_q == ST_FIN && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (is_calc) begin
            oor_q   <= in_oor;
            k_q     <= '0;
            state_q <= in_oor ? ST_FIN : ST_CALC;
          end
        end
        ST_CALC: begin
          if (rd_en) begin
            k_q <= k_q + NW'(1);
          end else if (!rd_vld_q && !mac_stat.busy) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_calc) begin
      row_q <= in_row;
      col_q <= in_col;
    end
    if (state_q == ST_FIN && out_free) begin
      out_row_q <= row_q;
      out_col_q <= col_q;
      out_val_q <= oor_q ? '0 : acc;
      out_oor_q <= oor_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - ACC_W - COL_W - ROW_W){1'b0}},
                            out_val_q, out_col_q, out_row_q};
  assign m_axis_tuser_o  = out_oor_q;

  // read walk never passes the matrix size
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |-> k_q <= n_eff)
    else $error("k counter beyond matrix size");

  // the MAC pipeline is empty whenever a new word may arrive
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !rd_vld_q && !mac_stat.busy)
    else $error("MAC pipeline busy while idle");

  // out-of-range results carry a zero value
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_oor_q |-> out_val_q == '0)
    else $error("out-of-range result with nonzero value");

  // a finished result is only loaded into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready_i && state_q == ST_FIN |=> state_q == ST_FIN)
    else $error("result overwrote a pending word");

endmodule

>>> verif/tb_matrix_multiply_engine.sv
// Self-checking testbench for the matrix multiply engine: loads, C element requests, size changes.
module tb_matrix_multiply_engine;
  import mme_pkg::*;

  localparam int unsigned DIM = 64;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // margin for a load in flight or an in-range request at full size to finish
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [ACC_W-1:0] product;
    logic             oor;
  } c_element_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_wr_en_i;
  logic [SIZE_W-1:0]      cfg_wr_data_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [0:0]             m_axis_tuser_o;

  // shadow copy of the block's stores and size register
  logic signed [VAL_W-1:0] a_store [DIM][DIM];
  logic signed [VAL_W-1:0] b_store [DIM][DIM];
  bit                      a_written [DIM][DIM];
  bit                      b_written [DIM][DIM];
  logic [SIZE_W-1:0]       size_reg;

  c_element_t  c_elements_due[$];
  int unsigned words_sent;
  int unsigned mismatches;
  bit          steady;  // no gaps and no stalls while set

  matrix_multiply_engine u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned active_dim();
    return (size_reg > DIM) ? DIM : int'(size_reg);
  endfunction

  function automatic c_element_t predict_c_element(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col);
    c_element_t  e;
    longint      sum;
    int unsigned n;
    n = active_dim();
    e.row = row;
    e.col = col;
    e.product = '0;
    e.oor = 1'b0;
    if (row >= n || col >= n) begin
      e.oor = 1'b1;
    end else begin
      sum = 0;
      for (int unsigned k = 0; k < n; k++) begin
        sum += longint'(a_store[row][k]) * longint'(b_store[k][col]);
      end
      e.product = sum[ACC_W-1:0];
    end
    return e;
  endfunction

  function automatic logic [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // one input word; the stores and the expectations follow at the accepting edge
  task automatic send_word(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                           logic [COL_W-1:0] col, logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, val, col, row, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    case (op)
      OP_LOAD_A: begin
        a_store[row][col]   = val;
        a_written[row][col] = 1'b1;
      end
      OP_LOAD_B: begin
        b_store[row][col]   = val;
        b_written[row][col] = 1'b1;
      end
      OP_CALC: c_elements_due.push_back(predict_c_element(row, col));
      default: ;
    endcase
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (c_elements_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_matrix_size(logic [SIZE_W-1:0] n);
    wait_idle();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= n;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    size_reg = n;
  endtask

  // loads every operand of C[row][col] not yet written, and refreshes a few
  task automatic load_operands(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    int unsigned n;
    n = active_dim();
    for (int unsigned k = 0; k < n; k++) begin
      if (!a_written[row][k] || $urandom_range(0, 9) == 0)
        send_word(OP_LOAD_A, row, COL_W'(k), draw_value());
      if (!b_written[k][col] || $urandom_range(0, 9) == 0)
        send_word(OP_LOAD_B, ROW_W'(k), col, draw_value());
    end
  endtask

  task automatic test_directed();
    write_matrix_size(7'd4);
    send_word(OP_LOAD_A, 6'd3, 6'd0, 16'h8000);
    send_word(OP_LOAD_A, 6'd3, 6'd1, 16'h8000);
    send_word(OP_LOAD_A, 6'd3, 6'd2, 16'h7fff);
    send_word(OP_LOAD_A, 6'd3, 6'd3, 16'h0001);
    send_word(OP_LOAD_B, 6'd0, 6'd3, 16'h8000);
    send_word(OP_LOAD_B, 6'd1, 6'd3, 16'h7fff);
    send_word(OP_LOAD_B, 6'd2, 6'd3, 16'h7fff);
    send_word(OP_LOAD_B, 6'd3, 6'd3, 16'hffff);
    send_word(OP_CALC, 6'd3, 6'd3, 16'h0000);
    // out-of-range requests: column, row, both at the far corner
    send_word(OP_CALC, 6'd0, 6'd4, 16'hffff);
    send_word(OP_CALC, 6'd4, 6'd0, 16'h0000);
    send_word(OP_CALC, 6'd63, 6'd63, 16'h0000);
    // unused opcode, then a load outside the active size
    send_word(OP_UNUSED, 6'd3, 6'd3, 16'h1234);
    send_word(OP_LOAD_A, 6'd63, 6'd63, 16'h5555);
    send_word(OP_LOAD_A, 6'd3, 6'd3, 16'h7fff);
    send_word(OP_CALC, 6'd3, 6'd3, 16'h0000);
  endtask

  task automatic test_size_extremes();
    write_matrix_size(7'd0);
    send_word(OP_CALC, 6'd0, 6'd0, 16'h0000);
    send_word(OP_CALC, 6'd3, 6'd3, 16'h0000);
    write_matrix_size(7'd64);
    for (int k = 0; k < DIM; k++) begin
      send_word(OP_LOAD_A, 6'd63, COL_W'(k), 16'h8000);
      send_word(OP_LOAD_B, ROW_W'(k), 6'd63, 16'h8000);
    end
    send_word(OP_CALC, 6'd63, 6'd63, 16'h0000);  // largest positive sum
    write_matrix_size(7'd127);                    // clamps to full size
    for (int k = 0; k < DIM; k++) send_word(OP_LOAD_B, ROW_W'(k), 6'd63, 16'h7fff);
    send_word(OP_CALC, 6'd63, 6'd63, 16'h0000);  // most negative sum
    write_matrix_size(7'd1);
    load_operands(6'd0, 6'd0);
    send_word(OP_CALC, 6'd0, 6'd0, 16'h0000);
    send_word(OP_CALC, 6'd0, 6'd1, 16'h0000);
  endtask

  task automatic test_random(int unsigned word_count);
    int unsigned stop_at;
    int unsigned phase_end;
    int unsigned n;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    stop_at = words_sent + word_count;
    while (words_sent < stop_at) begin
      case ($urandom_range(0, 9))
        6: write_matrix_size(SIZE_W'($urandom_range(9, 63)));
        7: write_matrix_size(7'd64);
        8: write_matrix_size(7'd0);
        9: write_matrix_size(SIZE_W'($urandom_range(65, 127)));
        default: write_matrix_size(SIZE_W'($urandom_range(1, 8)));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      n = active_dim();
      phase_end = words_sent + 150;
      while (words_sent < phase_end && words_sent < stop_at) begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            // request outside the active size, where one exists
            if (n < DIM) begin
              row = ROW_W'($urandom_range(0, 63));
              col = COL_W'($urandom_range(0, 63));
              if (n > 0) begin
                case ($urandom_range(0, 2))
                  0: row = ROW_W'($urandom_range(n, 63));
                  1: col = COL_W'($urandom_range(n, 63));
                  default: begin
                    row = ROW_W'($urandom_range(n, 63));
                    col = COL_W'($urandom_range(n, 63));
                  end
                endcase
              end
              send_word(OP_CALC, row, col, draw_value());
            end
          end
          3, 4, 5: send_word(($urandom_range(0, 1) == 0) ? OP_LOAD_A : OP_LOAD_B,
                             ROW_W'($urandom), COL_W'($urandom), draw_value());
          6: send_word(OP_UNUSED, ROW_W'($urandom), COL_W'($urandom), draw_value());
          default: begin
            if (n > 0) begin
              row = ROW_W'($urandom_range(0, n - 1));
              col = COL_W'($urandom_range(0, n - 1));
              load_operands(row, col);
              send_word(OP_CALC, row, col, draw_value());
            end
          end
        endcase
      end
      steady = 1'b0;
    end
  endtask

  // result side: stalls are drawn per word and held once the word is offered
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        do @(posedge clk_i); while (!m_axis_tvalid_o);
        repeat (stall - 1) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  always @(posedge clk_i) begin
    c_element_t due;
    c_element_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.row     = m_axis_tdata_o[5:0];
      got.col     = m_axis_tdata_o[11:6];
      got.product = m_axis_tdata_o[49:12];
      got.oor     = m_axis_tuser_o[0];
      if (c_elements_due.size() == 0) begin
        $error("unexpected result word: row %0d col %0d", got.row, got.col);
        mismatches++;
      end else begin
        due = c_elements_due.pop_front();
        if (got.row !== due.row) begin
          $error("result_row: expected %0d, got %0d", due.row, got.row);
          mismatches++;
        end
        if (got.col !== due.col) begin
          $error("result_col: expected %0d, got %0d", due.col, got.col);
          mismatches++;
        end
        if (got.product !== due.product) begin
          $error("product_value: expected %0d, got %0d",
                 $signed(due.product), $signed(got.product));
          mismatches++;
        end
        if (got.oor !== due.oor) begin
          $error("out_of_range: expected %0d, got %0d", due.oor, got.oor);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("matrix_multiply_engine regression: fail");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_wr_en_i     <= 1'b0;
    cfg_wr_data_i   <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    m_axis_tready_i <= 1'b0;
    size_reg    = SIZE_RESET;
    words_sent  = 0;
    mismatches  = 0;
    steady      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_size_extremes();
    test_random(1800);
    wait_idle();

    if (mismatches == 0) begin
      $display("matrix_multiply_engine regression: pass");
    end else begin
      $display("matrix_multiply_engine regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
sv/mme_pkg.sv
sv/mme_ram.sv
sv/mme_mac.sv
sv/matrix_multiply_engine.sv
verif/tb_matrix_multiply_engine.sv
